@@ design/lss_pkg.sv @@
package lss_pkg;

  localparam int DEFAULT_STACK_DEPTH = 16;
  localparam int WORD_W  = 32;
  localparam int REQ_W   = 3;
  localparam int IDX_W   = 4;
  localparam int FILL_W  = 5;
  localparam int STAT_W  = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SCALE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SC_RD,
    S_SC_MUL,
    S_SC_WR,
    S_FETCH,
    S_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic sc_rd;
    logic sc_mul;
    logic sc_wr;
    logic fetch;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic scale_go;
    logic sc_last;
    logic out_free;
  } dp_stat_t;

endpackage

@@ design/lss_ctrl.sv @@
module lss_ctrl
  import lss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_EXEC;
      S_EXEC:   state_nxt = stat.scale_go ? S_SC_RD : S_FETCH;
      S_SC_RD:  state_nxt = S_SC_MUL;
      S_SC_MUL: state_nxt = S_SC_WR;
      S_SC_WR:  state_nxt = stat.sc_last ? S_FETCH : S_SC_RD;
      S_FETCH:  state_nxt = S_RESP;
      S_RESP:   if (stat.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_EXEC:   cmd.exec     = 1'b1;
      S_SC_RD:  cmd.sc_rd    = 1'b1;
      S_SC_MUL: cmd.sc_mul   = 1'b1;
      S_SC_WR:  cmd.sc_wr    = 1'b1;
      S_FETCH:  cmd.fetch    = 1'b1;
      S_RESP:   cmd.load_out = stat.out_free;
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

@@ design/lss_dp.sv @@
module lss_dp
  import lss_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_cmd_t           cmd,
  output dp_stat_t           stat,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [WORD_W-1:0]  in_push_value,
  input  logic [WORD_W-1:0]  in_scale_factor,
  input  logic [IDX_W-1:0]   in_read_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [WORD_W-1:0]  out_top_word,
  output logic               out_is_empty,
  output logic [FILL_W-1:0]  out_fill_count,
  output logic [WORD_W-1:0]  out_read_word,
  output logic [STAT_W-1:0]  out_status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = (CW > FILL_W) ? CW : FILL_W;

  logic [WORD_W-1:0] mem [STACK_DEPTH];

  logic [REQ_W-1:0]  req_r;
  logic [WORD_W-1:0] value_r;
  logic [WORD_W-1:0] factor_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [CW-1:0]     sc_idx_r;
  logic [WORD_W-1:0] rd_a_r, rd_b_r, prod_r;
  logic              out_valid_r, out_valid_nxt;

  logic [EW-1:0]     count_ext, idx_ext, rd_pos;
  logic [CW-1:0]     top_pos;
  logic              full, empty;
  logic [AW-1:0]     addr_a, wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              wr_en, rd_en;

  assign count_ext = EW'(count_r);
  assign idx_ext   = EW'(idx_r);
  assign top_pos   = count_r - CW'(1);
  assign rd_pos    = count_ext - EW'(1) - idx_ext;
  assign full      = (count_r == CW'(STACK_DEPTH));
  assign empty     = (count_r == '0);

  assign addr_a  = cmd.fetch ? top_pos[AW-1:0] : sc_idx_r[AW-1:0];
  assign rd_en   = cmd.fetch || cmd.sc_rd;
  assign wr_en   = (cmd.exec && (req_r == REQ_PUSH) && !full) || cmd.sc_wr;
  assign wr_addr = cmd.sc_wr ? sc_idx_r[AW-1:0] : count_r[AW-1:0];
  assign wr_data = cmd.sc_wr ? prod_r : value_r;

  assign stat.scale_go = (req_r == REQ_SCALE) && !empty;
  assign stat.sc_last  = (sc_idx_r == top_pos);
  assign stat.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[addr_a];
      rd_b_r <= mem[rd_pos[AW-1:0]];
    end
  end

  // Request outcome, settled in the execute cycle.
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    unique case (req_r)
      REQ_PUSH: begin
        if (full) status_nxt = ST_FULL;
        else      count_nxt  = count_r + CW'(1);
      end
      REQ_POP: begin
        if (empty) status_nxt = ST_EMPTY;
        else       count_nxt  = top_pos;
      end
      REQ_CLEAR: count_nxt = '0;
      REQ_READ:  if (idx_ext >= count_ext) status_nxt = ST_RANGE;
      default: begin
        count_nxt  = count_r;
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r    <= in_req_type;
      value_r  <= in_push_value;
      factor_r <= in_scale_factor;
      idx_r    <= in_read_index;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      sc_idx_r <= '0;
    end else if (cmd.sc_wr) begin
      sc_idx_r <= sc_idx_r + CW'(1);
    end
    // Low word of the product is the same for signed and unsigned operands.
    if (cmd.sc_mul) begin
      prod_r <= rd_a_r * factor_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)    out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_top_word   <= empty ? '0 : rd_a_r;
      out_is_empty   <= empty;
      out_fill_count <= count_ext[FILL_W-1:0];
      out_read_word  <= ((req_r == REQ_READ) && (status_r == ST_OK)) ? rd_b_r : '0;
      out_status     <= status_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ design/lifo_stack_with_scale.sv @@
// LIFO stack of 32-bit words with whole-stack scaling.
// Input channel: in_valid / in_stall carry one request (push, pop, clear,
// scale all, read at depth). Result channel: out_valid / out_stall carry
// one result per request: top word, empty flag, fill count, read word and
// status. A transaction completes when valid is high and stall is low.
// Requests are handled one at a time by a controller and a datapath built
// around a single-write, dual-read stack memory with registered reads.
// Each request passes the execute, fetch and response states; a scale adds
// a read, multiply and write-back step per held entry in between, through
// the one multiplier. A new request is taken once the previous one has
// reached the output register, so a new request is not taken while the
// previous one is still being processed. While the receiver stalls the
// result register holds; the next request can still be accepted and is
// processed up to the point where it needs that register. Synchronous
// active-low reset empties the stack and drops any pending result; the
// memory itself is not cleared.
module lifo_stack_with_scale
  import lss_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic [WORD_W-1:0]        in_push_value,
  input  logic signed [WORD_W-1:0] in_scale_factor,
  input  logic [IDX_W-1:0]         in_read_index,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [WORD_W-1:0]        out_top_word,
  output logic                     out_is_empty,
  output logic [FILL_W-1:0]        out_fill_count,
  output logic [WORD_W-1:0]        out_read_word,
  output logic [STAT_W-1:0]        out_status
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  lss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lss_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (in_req_type),
    .in_push_value   (in_push_value),
    .in_scale_factor ($unsigned(in_scale_factor)),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_top_word    (out_top_word),
    .out_is_empty    (out_is_empty),
    .out_fill_count  (out_fill_count),
    .out_read_word   (out_read_word),
    .out_status      (out_status)
  );

  // One request in flight: the port closes right after a transaction.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a request is in flight");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_top_word == '0 && out_fill_count == '0))
    else $error("empty stack reports a top word or a count");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> !out_is_empty)
    else $error("full status on an empty stack");

  a_read_word_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_read_word == '0))
    else $error("read word set on a failed request");

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  import lss_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 9;
  localparam int DEPTH          = DEFAULT_STACK_DEPTH;
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4 + 3 * DEPTH + 8;
  localparam int CHUNK_ITEMS    = 40;

  // request codes the block ignores
  localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } traffic_mix_t;

  typedef struct packed {
    logic [WORD_W-1:0] top_word;
    logic              is_empty;
    logic [FILL_W-1:0] fill_count;
    logic [WORD_W-1:0] read_word;
    logic [STAT_W-1:0] status;
  } stack_rsp_t;

  logic                     clk             = 1'b0;
  logic                     rst_n           = 1'b0;
  logic                     in_valid        = 1'b0;
  logic                     in_stall;
  logic [REQ_W-1:0]         in_req_type     = '0;
  logic [WORD_W-1:0]        in_push_value   = '0;
  logic signed [WORD_W-1:0] in_scale_factor = '0;
  logic [IDX_W-1:0]         in_read_index   = '0;
  logic                     out_valid;
  logic                     out_stall       = 1'b0;
  logic [WORD_W-1:0]        out_top_word;
  logic                     out_is_empty;
  logic [FILL_W-1:0]        out_fill_count;
  logic [WORD_W-1:0]        out_read_word;
  logic [STAT_W-1:0]        out_status;

  // shadow copy of the stack
  logic [WORD_W-1:0] shadow_mem [DEPTH];
  int                shadow_cnt = 0;
  stack_rsp_t        pending_rsps [$];

  int          err_cnt          = 0;
  int unsigned rsp_checked      = 0;
  int unsigned stalled_in_cycles = 0;
  int unsigned req_seen [8];
  int unsigned status_seen [4];

  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  int hold_seq   = 0;
  int hold_seen  = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  lifo_stack_with_scale #(
    .STACK_DEPTH(DEPTH)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_push_value  (in_push_value),
    .in_scale_factor(in_scale_factor),
    .in_read_index  (in_read_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_top_word   (out_top_word),
    .out_is_empty   (out_is_empty),
    .out_fill_count (out_fill_count),
    .out_read_word  (out_read_word),
    .out_status     (out_status)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Apply one request to the shadow stack and return the result it causes.
  function automatic stack_rsp_t stack_response(input logic [REQ_W-1:0]  rq,
                                                input logic [WORD_W-1:0] val,
                                                input logic [WORD_W-1:0] factor,
                                                input logic [IDX_W-1:0]  idx);
    stack_rsp_t r;
    int         i;
    r        = '0;
    r.status = ST_OK;
    case (rq)
      REQ_PUSH: begin
        if (shadow_cnt >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_mem[shadow_cnt] = val;
          shadow_cnt++;
        end
      end
      REQ_POP: begin
        if (shadow_cnt == 0) r.status = ST_EMPTY;
        else shadow_cnt--;
      end
      REQ_CLEAR: begin
        shadow_cnt = 0;
      end
      REQ_SCALE: begin
        // low 32 bits of the product are the same for signed and unsigned
        for (i = 0; i < shadow_cnt; i++) shadow_mem[i] = shadow_mem[i] * factor;
      end
      REQ_READ: begin
        if (int'(idx) >= shadow_cnt) r.status = ST_RANGE;
        else r.read_word = shadow_mem[shadow_cnt - 1 - int'(idx)];
      end
      default: begin
      end
    endcase
    r.top_word   = (shadow_cnt == 0) ? '0 : shadow_mem[shadow_cnt - 1];
    r.is_empty   = (shadow_cnt == 0);
    r.fill_count = shadow_cnt[FILL_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("mismatch on %s at %0t: got %h, want %h", field, $time, got, want);
    err_cnt++;
  endtask

  // Offer one request, hold it until taken, then maybe drop valid for a while.
  task automatic send_req(input logic [REQ_W-1:0]  rq,
                          input logic [WORD_W-1:0] val,
                          input logic [WORD_W-1:0] factor,
                          input logic [IDX_W-1:0]  idx);
    stack_rsp_t r;
    in_valid        <= 1'b1;
    in_req_type     <= rq;
    in_push_value   <= val;
    in_scale_factor <= factor;
    in_read_index   <= idx;
    do @(posedge clk); while (in_stall);
    r = stack_response(rq, val, factor, idx);
    pending_rsps.push_back(r);
    req_seen[rq]++;
    status_seen[r.status]++;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_factor();
    int small_f;
    small_f = $urandom_range(0, 6) - 3;
    case ($urandom_range(0, 7))
      0: return -32'sd1;
      1: return '0;
      2: return 32'd1;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return small_f;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_req(input traffic_mix_t mix);
    int               pick;
    int               push_pct;
    int               pop_pct;
    logic [REQ_W-1:0] rq;
    pick = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin push_pct = 60; pop_pct = 10; end
      MIX_DRAIN: begin push_pct = 20; pop_pct = 45; end
      default:   begin push_pct = 38; pop_pct = 25; end
    endcase
    if (pick < push_pct) rq = REQ_PUSH;
    else if (pick < push_pct + pop_pct) rq = REQ_POP;
    else if (pick < 80) rq = REQ_READ;
    else if (pick < 94) rq = REQ_SCALE;
    else if (pick < 97) rq = REQ_CLEAR;
    else rq = REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
    send_req(rq, rand_word(), rand_factor(), IDX_W'($urandom_range(0, 15)));
  endtask

  task automatic test_empty_stack();
    send_req(REQ_POP,   32'h1234_5678, '0, 4'd0);
    send_req(REQ_READ,  '0, '0, 4'd15);
    send_req(REQ_READ,  '0, '0, 4'd0);
    send_req(REQ_SCALE, '0, -32'sd1, 4'd0);
    send_req(REQ_CLEAR, '1, '1, 4'd15);
    for (int c = REQ_SPARE_FIRST; c <= REQ_SPARE_LAST; c++) begin
      send_req(REQ_W'(c), $urandom, $urandom, IDX_W'($urandom_range(0, 15)));
    end
  endtask

  task automatic test_edge_words();
    send_req(REQ_PUSH,  '0, '0, 4'd0);
    send_req(REQ_PUSH,  '1, '0, 4'd0);
    send_req(REQ_PUSH,  32'h8000_0000, '0, 4'd0);
    send_req(REQ_PUSH,  32'h7FFF_FFFF, '0, 4'd0);
    send_req(REQ_READ,  '0, '0, 4'd0);
    send_req(REQ_READ,  '0, '0, 4'd3);
    send_req(REQ_READ,  '0, '0, 4'd4);
    send_req(REQ_SCALE, '0, -32'sd1, 4'd0);
    send_req(REQ_READ,  '0, '0, 4'd1);
    send_req(REQ_SCALE, '0, 32'h8000_0000, 4'd0);
    send_req(REQ_READ,  '0, '0, 4'd0);
    send_req(REQ_SCALE, '0, 32'h7FFF_FFFF, 4'd0);
    send_req(REQ_POP,   '0, '0, 4'd0);
    send_req(REQ_CLEAR, '0, '0, 4'd0);
    send_req(REQ_POP,   '0, '0, 4'd0);
  endtask

  // Fill the stack back to back, starting with a long hold-off on the result side.
  task automatic test_full_under_backpressure();
    tx_idle_en = 1'b0;
    hold_seq++;
    for (int n = 0; n < DEPTH; n++) send_req(REQ_PUSH, $urandom, '0, 4'd0);
    send_req(REQ_PUSH,  '1, '0, 4'd0);
    send_req(REQ_READ,  '0, '0, 4'd15);
    send_req(REQ_READ,  '0, '0, 4'd0);
    send_req(REQ_SCALE, '0, 32'd3, 4'd0);
    send_req(REQ_READ,  '0, '0, 4'd15);
    send_req(REQ_POP,   '0, '0, 4'd0);
    send_req(REQ_READ,  '0, '0, 4'd15);
  endtask

  task automatic test_random_traffic(input int chunks, input bit allow_idle);
    traffic_mix_t mix;
    for (int ch = 0; ch < chunks; ch++) begin
      mix        = traffic_mix_t'($urandom_range(0, 2));
      tx_idle_en = allow_idle && ($urandom_range(0, 3) != 0);
      rx_idle_en = allow_idle && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < CHUNK_ITEMS; n++) send_random_req(mix);
    end
  endtask

  // result side: random stall bursts, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_seq) begin
      hold_seen  = hold_seq;
      stall_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    stack_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsps.size() == 0) begin
        report_mismatch("unexpected result", out_top_word, '0);
      end else begin
        want = pending_rsps.pop_front();
        rsp_checked++;
        if (out_top_word !== want.top_word)
          report_mismatch("top_word", out_top_word, want.top_word);
        if (out_is_empty !== want.is_empty)
          report_mismatch("is_empty", WORD_W'(out_is_empty), WORD_W'(want.is_empty));
        if (out_fill_count !== want.fill_count)
          report_mismatch("fill_count", WORD_W'(out_fill_count), WORD_W'(want.fill_count));
        if (out_read_word !== want.read_word)
          report_mismatch("read_word", out_read_word, want.read_word);
        if (out_status !== want.status)
          report_mismatch("status", WORD_W'(out_status), WORD_W'(want.status));
      end
    end
  end

  // end the run if no transaction completes on either side for too long
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) stalled_in_cycles++;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, pending_rsps.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stack();
    test_edge_words();
    test_full_under_backpressure();
    test_random_traffic(14, 1'b1);
    test_random_traffic(4, 1'b0);
    in_valid <= 1'b0;

    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: push %0d, pop %0d, clear %0d, scale %0d, read %0d, spare %0d",
             req_seen.sum(), req_seen[REQ_PUSH], req_seen[REQ_POP], req_seen[REQ_CLEAR],
             req_seen[REQ_SCALE], req_seen[REQ_READ],
             req_seen.sum() - req_seen[REQ_PUSH] - req_seen[REQ_POP] - req_seen[REQ_CLEAR]
             - req_seen[REQ_SCALE] - req_seen[REQ_READ]);
    $display({"%0d results checked; full %0d, empty pop %0d, bad index %0d; ",
              "input stalled %0d cycles"},
             rsp_checked, status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_RANGE],
             stalled_in_cycles);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
